>>> sv/sca_pkg.sv
// Package with shared constants and types of the stereo correlation time aligner.
`default_nettype none
package sca_pkg;

   localparam int CAPTURE_LEN = 512;
   localparam int DELAY_DEPTH = 2048;
   localparam int SAMPLE_BITS = 24;
   localparam int CAP_AW = $clog2(CAPTURE_LEN);
   localparam int DLY_AW = $clog2(DELAY_DEPTH);
   localparam int PROD_W = 2 * SAMPLE_BITS;
   localparam int ACC_W = 64;
   localparam int LAG_OUT_W = 9;
   localparam int CSR_AW = 3;

   localparam logic REG_MONO = 1'b0;
   localparam logic REG_ALIGN = 1'b1;

   typedef struct packed {
      logic              done;
      logic [CAP_AW-1:0] lag;
      logic              negative;
   } corr_status_type;

endpackage
`default_nettype wire

>>> sv/sca_ram.sv
// Simple dual-port memory with one write port and one registered read port.
`default_nettype none
module sca_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 24
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> sv/sca_corr.sv
// Capture buffers and an iterative multiply-accumulate engine for the lag search.
`default_nettype none
module sca_corr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            cap_wr_en,
   input  wire logic [sca_pkg::CAP_AW-1:0]      cap_wr_addr,
   input  wire logic [sca_pkg::SAMPLE_BITS-1:0] cap_left,
   input  wire logic [sca_pkg::SAMPLE_BITS-1:0] cap_right,
   input  wire logic                            start,
   output sca_pkg::corr_status_type             status
);

   typedef enum logic [2:0] {
      C_IDLE, C_RD, C_MUL, C_ACC, C_CMP, C_DONE
   } corr_state_type;

   corr_state_type                     state_ff, state_in;
   logic [sca_pkg::CAP_AW-1:0]         i_ff, i_in, j_ff, j_in;
   logic signed [sca_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [sca_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [sca_pkg::ACC_W-1:0]          best_ff, best_in;
   logic [sca_pkg::CAP_AW-1:0]         lag_ff, lag_in;
   logic                               neg_ff, neg_in;
   logic [sca_pkg::SAMPLE_BITS-1:0]    left_rd, right_rd;
   logic [sca_pkg::ACC_W-1:0]          mag;
   logic [sca_pkg::CAP_AW-1:0]         right_addr;

   assign right_addr = i_ff + j_ff;

   sca_ram #(.DEPTH(sca_pkg::CAPTURE_LEN), .WIDTH(sca_pkg::SAMPLE_BITS)) u_left (
      .clock(clock), .wr_en(cap_wr_en), .wr_addr(cap_wr_addr), .wr_data(cap_left),
      .rd_addr(j_ff), .rd_data_ff(left_rd)
   );

   sca_ram #(.DEPTH(sca_pkg::CAPTURE_LEN), .WIDTH(sca_pkg::SAMPLE_BITS)) u_right (
      .clock(clock), .wr_en(cap_wr_en), .wr_addr(cap_wr_addr), .wr_data(cap_right),
      .rd_addr(right_addr), .rd_data_ff(right_rd)
   );

   assign mag = acc_ff[sca_pkg::ACC_W-1] ? (sca_pkg::ACC_W'(0) - acc_ff) : acc_ff;

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      best_in = best_ff;
      lag_in = lag_ff;
      neg_in = neg_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               i_in = '0;
               j_in = '0;
               acc_in = '0;
               best_in = '0;
               lag_in = '0;
               neg_in = 1'b0;
               state_in = C_RD;
            end
         end
         C_RD: begin
            state_in = C_MUL;
         end
         C_MUL: begin
            prod_in = $signed(left_rd) * $signed(right_rd);
            state_in = C_ACC;
         end
         C_ACC: begin
            acc_in = acc_ff + {{(sca_pkg::ACC_W-sca_pkg::PROD_W){prod_ff[sca_pkg::PROD_W-1]}},
                               prod_ff};
            if (j_ff == sca_pkg::CAP_AW'(sca_pkg::CAPTURE_LEN - 1)) begin
               state_in = C_CMP;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = C_RD;
            end
         end
         C_CMP: begin
            if (mag > best_ff) begin
               best_in = mag;
               lag_in = i_ff;
               neg_in = acc_ff[sca_pkg::ACC_W-1];
            end
            acc_in = '0;
            j_in = '0;
            if (i_ff == sca_pkg::CAP_AW'(sca_pkg::CAPTURE_LEN - 1)) begin
               state_in = C_DONE;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = C_RD;
            end
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      best_ff <= best_in;
      lag_ff <= lag_in;
      neg_ff <= neg_in;
   end

   assign status.done = (state_ff == C_DONE);
   assign status.lag = lag_ff;
   assign status.negative = neg_ff;

endmodule
`default_nettype wire

>>> sv/stereo_correlation_time_aligner.sv
// Top level: request sequencer, capture control, left delay line and output mixing.
// A response follows the delay-line states S_DWR, S_DRD and S_DWAIT of an accepted request.
// A request that completes a capture first runs the lag search (state S_CORR), which is paced
// by the single shared multiply-accumulate unit stepping through every lag and every sample.
// One request at a time: a new request is taken only after the response has been accepted.
// Reset is synchronous; the delay line reads as zero until each entry is written, no clearing pass.
`default_nettype none
module stereo_correlation_time_aligner (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [sca_pkg::SAMPLE_BITS-1:0] req_in_left,
   input  wire logic [sca_pkg::SAMPLE_BITS-1:0] req_in_right,
   input  wire logic                            req_start_detect,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [sca_pkg::SAMPLE_BITS-1:0]      rsp_out_left,
   output logic [sca_pkg::SAMPLE_BITS-1:0]      rsp_out_right,
   output logic [sca_pkg::LAG_OUT_W-1:0]        rsp_detected_lag,
   output logic                                 rsp_polarity_negative,
   output logic                                 rsp_detect_done,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [sca_pkg::CSR_AW-1:0]      csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE, S_CORR, S_DWR, S_DRD, S_DWAIT, S_OUT
   } top_state_type;

   top_state_type                   state_ff;
   logic                            mono_ff, align_ff;
   logic                            phase_ff;
   logic [sca_pkg::CAP_AW:0]        count_ff;
   logic [sca_pkg::CAP_AW-1:0]      cur_lag_ff;
   logic                            cur_neg_ff;
   logic [sca_pkg::DLY_AW-1:0]      wp_ff, rd_ff;
   logic                            wrapped_ff, rd_valid_ff;
   logic [sca_pkg::SAMPLE_BITS-1:0] left_ff, right_ff;
   logic                            done_ff;
   logic [sca_pkg::SAMPLE_BITS-1:0] out_left_ff, out_right_ff;
   logic                            accept, collect, cap_last, corr_start, csr_wr;
   logic [sca_pkg::CAP_AW:0]        count_next;
   logic [sca_pkg::DLY_AW-1:0]      shift;
   logic [sca_pkg::SAMPLE_BITS-1:0] dly_rd, ol;
   logic [sca_pkg::SAMPLE_BITS:0]   sum;
   sca_pkg::corr_status_type        corr_status;

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign collect = phase_ff || req_start_detect;
   assign count_next = count_ff + 1'b1;
   assign cap_last = (count_next == (sca_pkg::CAP_AW+1)'(sca_pkg::CAPTURE_LEN));
   assign corr_start = accept && collect && cap_last;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, (csr_paddr[2] == sca_pkg::REG_ALIGN) ? align_ff : mono_ff};

   sca_corr u_corr (
      .clock(clock), .reset(reset),
      .cap_wr_en(accept && collect), .cap_wr_addr(count_ff[sca_pkg::CAP_AW-1:0]),
      .cap_left(req_in_left), .cap_right(req_in_right),
      .start(corr_start), .status(corr_status)
   );

   sca_ram #(.DEPTH(sca_pkg::DELAY_DEPTH), .WIDTH(sca_pkg::SAMPLE_BITS)) u_delay (
      .clock(clock), .wr_en(state_ff == S_DWR), .wr_addr(wp_ff), .wr_data(left_ff),
      .rd_addr(rd_ff), .rd_data_ff(dly_rd)
   );

   assign shift = align_ff ? sca_pkg::DLY_AW'(cur_lag_ff) : '0;
   assign ol = rd_valid_ff ? dly_rd : '0;
   assign sum = {ol[sca_pkg::SAMPLE_BITS-1], ol} + {right_ff[sca_pkg::SAMPLE_BITS-1], right_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mono_ff <= 1'b0;
         align_ff <= 1'b0;
         phase_ff <= 1'b0;
         count_ff <= '0;
         cur_lag_ff <= '0;
         cur_neg_ff <= 1'b0;
         wp_ff <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_paddr[2])
               sca_pkg::REG_MONO: mono_ff <= csr_pwdata[0];
               sca_pkg::REG_ALIGN: align_ff <= csr_pwdata[0];
               default: mono_ff <= mono_ff;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  left_ff <= req_in_left;
                  right_ff <= req_in_right;
                  done_ff <= 1'b0;
                  state_ff <= S_DWR;
                  if (collect) begin
                     if (cap_last) begin
                        phase_ff <= 1'b0;
                        count_ff <= '0;
                        done_ff <= 1'b1;
                        state_ff <= S_CORR;
                     end else begin
                        phase_ff <= 1'b1;
                        count_ff <= count_next;
                     end
                  end
               end
            end
            S_CORR: begin
               if (corr_status.done) begin
                  cur_lag_ff <= corr_status.lag;
                  cur_neg_ff <= corr_status.negative;
                  state_ff <= S_DWR;
               end
            end
            S_DWR: begin
               rd_ff <= wp_ff - shift;
               rd_valid_ff <= wrapped_ff || ((wp_ff - shift) <= wp_ff);
               state_ff <= S_DRD;
            end
            S_DRD: begin
               state_ff <= S_DWAIT;
            end
            S_DWAIT: begin
               if (mono_ff) begin
                  out_left_ff <= sum[sca_pkg::SAMPLE_BITS:1];
                  out_right_ff <= sum[sca_pkg::SAMPLE_BITS:1];
               end else begin
                  out_left_ff <= ol;
                  out_right_ff <= right_ff;
               end
               if (wp_ff == sca_pkg::DLY_AW'(sca_pkg::DELAY_DEPTH - 1)) begin
                  wrapped_ff <= 1'b1;
               end
               wp_ff <= wp_ff + 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_out_left = out_left_ff;
   assign rsp_out_right = out_right_ff;
   assign rsp_detected_lag = sca_pkg::LAG_OUT_W'(cur_lag_ff);
   assign rsp_polarity_negative = cur_neg_ff;
   assign rsp_detect_done = done_ff;

endmodule
`default_nettype wire

>>> dv/stereo_correlation_time_aligner_tb.sv
// Self-checking testbench for the stereo correlation time aligner with an in-bench predictor.
`default_nettype none
module stereo_correlation_time_aligner_tb;

   localparam int PERIOD = 4;
   localparam int MAX_ERR_SHOWN = 10;
   localparam logic [sca_pkg::CSR_AW-1:0] ADDR_MONO =
      sca_pkg::CSR_AW'(4 * int'(sca_pkg::REG_MONO));
   localparam logic [sca_pkg::CSR_AW-1:0] ADDR_ALIGN =
      sca_pkg::CSR_AW'(4 * int'(sca_pkg::REG_ALIGN));

   typedef struct packed {
      logic [sca_pkg::SAMPLE_BITS-1:0] left;
      logic [sca_pkg::SAMPLE_BITS-1:0] right;
      logic [sca_pkg::LAG_OUT_W-1:0]   lag;
      logic                            negative;
      logic                            done;
   } pair_out_type;

   class aligner_scoreboard;
      logic [sca_pkg::SAMPLE_BITS-1:0] delay_line [sca_pkg::DELAY_DEPTH];
      logic [sca_pkg::DLY_AW-1:0]      wr_ptr;
      longint                          cap_left [sca_pkg::CAPTURE_LEN];
      longint                          cap_right [sca_pkg::CAPTURE_LEN];
      int                              cap_count;
      bit                              collecting;
      logic [sca_pkg::CAP_AW-1:0]      lag;
      logic                            negative;
      bit                              mono;
      bit                              align;
      pair_out_type                    pending [$];
      int                              errors;
      int                              checked;
      int                              detections;

      function void init();
         foreach (delay_line[i]) delay_line[i] = '0;
         wr_ptr = '0;
         cap_count = 0;
         collecting = 0;
         lag = '0;
         negative = 1'b0;
         mono = 0;
         align = 0;
         errors = 0;
         checked = 0;
         detections = 0;
      endfunction

      function void search_lag();
         bit [63:0] best;
         bit [63:0] acc;
         bit [63:0] mag;
         best = '0;
         lag = '0;
         negative = 1'b0;
         for (int i = 0; i < sca_pkg::CAPTURE_LEN; i++) begin
            acc = '0;
            for (int j = 0; j < sca_pkg::CAPTURE_LEN; j++)
               acc += 64'(cap_left[j] * cap_right[(i + j) % sca_pkg::CAPTURE_LEN]);
            mag = acc[63] ? -acc : acc;
            if (mag > best) begin
               best = mag;
               lag = sca_pkg::CAP_AW'(i);
               negative = acc[63];
            end
         end
      endfunction

      function void note_request(logic [sca_pkg::SAMPLE_BITS-1:0] l,
                                 logic [sca_pkg::SAMPLE_BITS-1:0] r, logic start);
         pair_out_type exp_out;
         longint ol;
         longint orr;
         longint sum;
         logic [sca_pkg::DLY_AW-1:0] rd;
         exp_out.done = 1'b0;
         if (!collecting && start) begin
            collecting = 1;
            cap_count = 0;
         end
         if (collecting) begin
            cap_left[cap_count] = longint'(signed'(l));
            cap_right[cap_count] = longint'(signed'(r));
            cap_count++;
            if (cap_count >= sca_pkg::CAPTURE_LEN) begin
               search_lag();
               collecting = 0;
               cap_count = 0;
               exp_out.done = 1'b1;
               detections++;
            end
         end
         delay_line[wr_ptr] = l;
         rd = align ? wr_ptr - sca_pkg::DLY_AW'(lag) : wr_ptr;
         ol = longint'(signed'(delay_line[rd]));
         orr = longint'(signed'(r));
         wr_ptr++;
         if (mono) begin
            sum = (ol + orr) >>> 1;
            ol = sum;
            orr = sum;
         end
         exp_out.left = sca_pkg::SAMPLE_BITS'(ol);
         exp_out.right = sca_pkg::SAMPLE_BITS'(orr);
         exp_out.lag = sca_pkg::LAG_OUT_W'(lag);
         exp_out.negative = negative;
         pending.push_back(exp_out);
      endfunction

      function void check_response(pair_out_type got);
         pair_out_type exp_out;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= MAX_ERR_SHOWN)
               $display("Unexpected response: left %h right %h", got.left, got.right);
            return;
         end
         exp_out = pending.pop_front();
         if (got != exp_out) begin
            errors++;
            if (errors <= MAX_ERR_SHOWN) begin
               $display("Mismatch on response %0d: expected %h %h lag %0d neg %b done %b,",
                        checked, exp_out.left, exp_out.right, exp_out.lag,
                        exp_out.negative, exp_out.done);
               $display("   got %h %h lag %0d neg %b done %b",
                        got.left, got.right, got.lag, got.negative, got.done);
            end
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [sca_pkg::SAMPLE_BITS-1:0] req_in_left;
   logic [sca_pkg::SAMPLE_BITS-1:0] req_in_right;
   logic                            req_start_detect;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [sca_pkg::SAMPLE_BITS-1:0] rsp_out_left;
   logic [sca_pkg::SAMPLE_BITS-1:0] rsp_out_right;
   logic [sca_pkg::LAG_OUT_W-1:0]   rsp_detected_lag;
   logic                            rsp_polarity_negative;
   logic                            rsp_detect_done;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [sca_pkg::CSR_AW-1:0]      csr_paddr;
   logic [31:0]                     csr_pwdata;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   aligner_scoreboard sb;
   int calm_req;
   int calm_rsp;

   stereo_correlation_time_aligner dut (.*);

   always begin
      clock = 1'b1;
      #(PERIOD / 2);
      clock = 1'b0;
      #(PERIOD / 2);
   end

   function automatic int draw_gap(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 15);
   endfunction

   task automatic send_pair(logic [sca_pkg::SAMPLE_BITS-1:0] l,
                            logic [sca_pkg::SAMPLE_BITS-1:0] r, logic s);
      int gap;
      gap = draw_gap(calm_req);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_left <= l;
      req_in_right <= r;
      req_start_detect <= s;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_request(l, r, s);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [sca_pkg::CSR_AW-1:0] addr, logic [31:0] data);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_MONO) sb.mono = data[0];
      else sb.align = data[0];
   endtask

   task automatic set_mode(bit mono, bit align);
      csr_write(ADDR_MONO, {31'($urandom_range(0, 32'h7fff_ffff)), mono});
      csr_write(ADDR_ALIGN, {31'($urandom_range(0, 32'h7fff_ffff)), align});
   endtask

   task automatic send_extremes();
      logic [sca_pkg::SAMPLE_BITS-1:0] edges [5];
      edges = '{24'h800000, 24'h7fffff, 24'h000000, 24'hffffff, 24'h000001};
      for (int i = 0; i < 5; i++)
         send_pair(edges[i], edges[(i * 3 + 1) % 5], 1'b0);
   endtask

   task automatic send_random(int count);
      logic [sca_pkg::SAMPLE_BITS-1:0] l;
      logic [sca_pkg::SAMPLE_BITS-1:0] r;
      for (int i = 0; i < count; i++) begin
         l = sca_pkg::SAMPLE_BITS'($urandom);
         r = sca_pkg::SAMPLE_BITS'($urandom);
         if ($urandom_range(0, 7) == 0)
            l = {l[sca_pkg::SAMPLE_BITS-1], {(sca_pkg::SAMPLE_BITS-1){~l[sca_pkg::SAMPLE_BITS-1]}}};
         send_pair(l, r, 1'b0);
      end
   endtask

   task automatic run_capture();
      logic [sca_pkg::SAMPLE_BITS-1:0] src [sca_pkg::CAPTURE_LEN];
      logic [sca_pkg::SAMPLE_BITS-1:0] r;
      int shift;
      bit invert;
      shift = $urandom_range(1, sca_pkg::CAPTURE_LEN - 1);
      invert = $urandom_range(0, 1);
      foreach (src[k]) src[k] = sca_pkg::SAMPLE_BITS'($urandom);
      for (int k = 0; k < sca_pkg::CAPTURE_LEN; k++) begin
         r = src[(k - shift + sca_pkg::CAPTURE_LEN) % sca_pkg::CAPTURE_LEN];
         if (invert) r = -r;
         send_pair(src[k], r, k == 0 ? 1'b1 : logic'($urandom_range(0, 15) == 0));
      end
   endtask

   always @(posedge clock) begin
      pair_out_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.left = rsp_out_left;
         got.right = rsp_out_right;
         got.lag = rsp_detected_lag;
         got.negative = rsp_polarity_negative;
         got.done = rsp_detect_done;
         sb.check_response(got);
      end
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = draw_gap(calm_rsp);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   initial begin
      #(PERIOD * 4_000_000);
      $display("Timeout with %0d responses outstanding.", sb.pending.size());
      $display("stereo_correlation_time_aligner_tb: errors");
      $finish;
   end

   initial begin
      sb = new();
      sb.init();
      calm_req = 0;
      calm_rsp = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_left = '0;
      req_in_right = '0;
      req_start_detect = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_extremes();
      set_mode(1, 0);
      send_extremes();
      send_pair(24'h000001, 24'hfffffe, 1'b0);
      send_pair(24'h800000, 24'h800001, 1'b0);
      set_mode(0, 1);
      send_random(10);
      run_capture();
      send_random(40);
      set_mode(1, 1);
      send_extremes();
      send_random(30);
      set_mode(1, 0);
      send_random(15);
      set_mode(0, 0);
      send_random(15);
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Checked %0d responses across four mode settings, %0d lag detection(s).",
               sb.checked, sb.detections);
      $display("Final lag %0d, polarity negative %b.", sb.lag, sb.negative);
      if (sb.errors == 0) begin
         $display("stereo_correlation_time_aligner_tb: clean");
      end else begin
         $display("%0d mismatches in total.", sb.errors);
         $display("stereo_correlation_time_aligner_tb: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
